// ===== hdl/lstm_cell_pointwise_update_macros.svh =====
// Assertion macros shared by the LSTM pointwise update checkers.
// Depends on nothing; included by the checker file.
`ifndef LSTM_CELL_POINTWISE_UPDATE_MACROS_SVH
`define LSTM_CELL_POINTWISE_UPDATE_MACROS_SVH

// valid must stay up until the item is taken
`define LCPU_ASSERT_HOLD(label, clk, rstn, vld, rdy) \
    label: assert property (@(posedge clk) disable iff (!rstn) (vld && !rdy) |=> vld) \
        else $error("valid dropped before the item was taken");

// a stalled payload must not move
`define LCPU_ASSERT_STALL_STABLE(label, clk, rstn, vld, rdy, sig) \
    label: assert property (@(posedge clk) disable iff (!rstn) (vld && !rdy) |=> $stable(sig)) \
        else $error("payload changed while stalled");

// a condition that must hold on every clock outside reset
`define LCPU_ASSERT_COND(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!rstn) cond) \
        else $error("pointwise update invariant violated");

// a flag must be low in the cycle after reset is applied
`define LCPU_ASSERT_RESET(label, clk, rstn, sig) \
    label: assert property (@(posedge clk) !rstn |=> !sig) \
        else $error("flag not cleared by reset");

`endif

// ===== hdl/lcpu_pkg.sv =====
// Package for the LSTM pointwise update: sizes, pipeline control type and
// the fixed-point activation and rounding functions. Depends on nothing.
package lcpu_pkg;

    // hidden units per direction bank
    localparam int unsigned UNITS     = 256;
    localparam int unsigned MEM_DEPTH = 2 * UNITS;
    localparam int unsigned ADDR_W    = $clog2(MEM_DEPTH);

    // reciprocal used for unit_index mod UNITS (index is 8 bits)
    localparam int unsigned UNIT_RECIP = 65536 / UNITS;

    // pipeline depth, and the stage that may hold on a cell dependency
    localparam int STAGES     = 7;
    localparam int HOLD_STAGE = 1;

    // Q1.14 one and the saturated Q5.12 cell range
    localparam logic [19:0]        ONE_Q14  = 20'd16384;
    localparam logic signed [33:0] CELL_MAX = 34'sd131071;
    localparam logic signed [33:0] CELL_MIN = -34'sd131072;

    typedef struct packed {
        logic [STAGES-1:0] valid;    // stage holds an item
        logic [STAGES-1:0] load;     // stage register takes new contents
        logic [STAGES-1:0] advance;  // stage item moves on this edge
    } pipe_ctrl_t;

    // unit_index mod UNITS: reciprocal multiply plus one correction
    function automatic logic [7:0] unit_slot(input logic [7:0] u);
        logic [24:0] prod;
        logic [7:0]  quo;
        logic [20:0] rem;
        prod = 25'(u) * 25'(UNIT_RECIP);
        quo  = prod[23:16];
        rem  = 21'(u) - 21'(quo) * 21'(UNITS);
        if (rem >= 21'(UNITS)) begin
            rem = rem - 21'(UNITS);
        end
        return rem[7:0];
    endfunction

    // Piecewise-linear sigmoid, result Q1.14 in 0..16384.
    // frac11 set: argument has 11 fractional bits, else 10.
    function automatic logic [14:0] sigmoid_q14(input logic signed [17:0] a,
                                                input logic frac11);
        logic [17:0] mag;
        logic [19:0] me;
        logic [19:0] y;
        mag = a[17] ? 18'(-a) : 18'(a);
        me  = 20'(mag);
        if (frac11) begin
            if (mag >= 18'd10240)     y = ONE_Q14;
            else if (mag >= 18'd4864) y = 20'd13824 + (me >> 2);
            else if (mag >= 18'd2048) y = 20'd10240 + me;
            else                      y = 20'd8192 + (me << 1);
        end else begin
            if (mag >= 18'd5120)      y = ONE_Q14;
            else if (mag >= 18'd2432) y = 20'd13824 + (me >> 1);
            else if (mag >= 18'd1024) y = 20'd10240 + (me << 1);
            else                      y = 20'd8192 + (me << 2);
        end
        // negative argument mirrors around one half
        if (a[17]) begin
            y = ONE_Q14 - y;
        end
        return y[14:0];
    endfunction

    // tanh(x) = 2*sigmoid(2x) - 1; frac11 refers to the sigmoid argument
    function automatic logic signed [15:0] tanh_q14(input logic signed [17:0] a,
                                                    input logic frac11);
        logic [14:0]        s;
        logic signed [16:0] t;
        s = sigmoid_q14(a, frac11);
        t = $signed({1'b0, s, 1'b0}) - 17'sd16384;
        return t[15:0];
    endfunction

    // arithmetic shift right, round to nearest, ties away from zero
    function automatic logic signed [33:0] round_sh(input logic signed [33:0] v,
                                                    input int unsigned sh);
        logic signed [33:0] half;
        half = 34'sd1 <<< (sh - 1);
        if (v < 0) begin
            return (v + half - 34'sd1) >>> sh;
        end
        return (v + half) >>> sh;
    endfunction

endpackage

// ===== hdl/lcpu_cell_store.sv =====
// Cell state memory: one write port, one read port with registered data.
// Depends on lcpu_pkg for depth and address width.
module lcpu_cell_store (
    input  logic                             aclk,
    input  logic                             wr_en,
    input  logic [lcpu_pkg::ADDR_W-1:0]      wr_addr,
    input  logic signed [17:0]               wr_data,
    input  logic                             rd_en,
    input  logic [lcpu_pkg::ADDR_W-1:0]      rd_addr,
    output logic signed [17:0]               rd_data
);

    logic signed [17:0] mem [lcpu_pkg::MEM_DEPTH];
    logic signed [17:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, old data on a same-address write
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/lcpu_pipe_ctrl.sv =====
// Valid/ready control for the pointwise update pipeline: per-stage valid
// bits, bubble collapsing and a hold on the cell-dependency stage.
// Depends on lcpu_pkg.
module lcpu_pipe_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    input  logic                 hold,
    output lcpu_pkg::pipe_ctrl_t ctrl
);

    localparam int N = lcpu_pkg::STAGES;

    logic [N-1:0] valid_reg;
    logic [N-1:0] valid_next;
    logic [N-1:0] ready;
    logic [N-1:0] go;

    // ready ripples back from the output; a stage moves when the next frees
    always_comb begin
        ready[N-1] = !valid_reg[N-1] || m_ready;
        go[N-1]    = valid_reg[N-1] && m_ready;
        for (int k = N - 2; k >= 0; k--) begin
            go[k]    = valid_reg[k] && ready[k+1] && !(k == lcpu_pkg::HOLD_STAGE && hold);
            ready[k] = !valid_reg[k] || go[k];
        end
    end

    // valid bits follow their items
    always_comb begin
        valid_next[0] = ready[0] ? s_valid : valid_reg[0];
        for (int k = 1; k < N; k++) begin
            valid_next[k] = ready[k] ? go[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign ctrl.valid   = valid_reg;
    assign ctrl.load    = ready;
    assign ctrl.advance = go;
    assign s_ready      = ready[0];
    assign m_valid      = valid_reg[N-1];

endmodule

// ===== hdl/lstm_cell_pointwise_update.sv =====
// Pointwise LSTM cell update, seven register stages.
// Throughput: one item per cycle while m_ready is high; a continuation item for the
// same direction and unit as the item directly ahead waits for that cell value.
// Reset (aresetn low, synchronous) empties the pipeline; cell store is not cleared.
// Depends on lcpu_pkg, lcpu_pipe_ctrl and lcpu_cell_store.
module lstm_cell_pointwise_update (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_unit_index,
    input  logic               s_direction,
    input  logic               s_first_step,
    input  logic signed [15:0] s_pre_input_gate,
    input  logic signed [15:0] s_pre_candidate,
    input  logic signed [15:0] s_pre_output_gate,
    input  logic signed [15:0] s_pre_forget_gate,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [7:0]         m_out_unit,
    output logic               m_out_direction,
    output logic signed [15:0] m_hidden_value,
    output logic signed [17:0] m_cell_value,
    output logic               m_cell_saturated
);

    localparam int AW = lcpu_pkg::ADDR_W;

    lcpu_pkg::pipe_ctrl_t ctrl;
    logic                 hazard;

    // stage 1: registered input item and store address
    logic [7:0]         s1_unit_reg;
    logic               s1_dir_reg;
    logic               s1_first_reg;
    logic [AW-1:0]      s1_addr_reg;
    logic [AW-1:0]      s1_addr_next;
    logic signed [15:0] s1_pi_reg;
    logic signed [15:0] s1_pc_reg;
    logic signed [15:0] s1_po_reg;
    logic signed [15:0] s1_pf_reg;

    // stage 2: activations and previous cell
    logic [7:0]         s2_unit_reg;
    logic               s2_dir_reg;
    logic               s2_first_reg;
    logic [AW-1:0]      s2_addr_reg;
    logic [14:0]        s2_ig_reg;
    logic signed [15:0] s2_cg_reg;
    logic [14:0]        s2_og_reg;
    logic [14:0]        s2_fg_reg;
    logic               s2_use_mem_reg;
    logic signed [17:0] s2_fwd_reg;
    logic signed [17:0] s2_prev;

    // stage 3: the two cell products
    logic [7:0]         s3_unit_reg;
    logic               s3_dir_reg;
    logic               s3_first_reg;
    logic [AW-1:0]      s3_addr_reg;
    logic [14:0]        s3_og_reg;
    logic signed [31:0] s3_ci_reg;
    logic signed [31:0] s3_ci_next;
    logic signed [33:0] s3_fp_reg;
    logic signed [33:0] s3_fp_next;

    // stage 4: saturated cell
    logic [7:0]         s4_unit_reg;
    logic               s4_dir_reg;
    logic [14:0]        s4_og_reg;
    logic signed [17:0] s4_cell_reg;
    logic signed [17:0] s4_cell_next;
    logic               s4_sat_reg;
    logic               s4_sat_next;
    logic signed [33:0] cell_sum;

    // stage 5: tanh of the cell
    logic [7:0]         s5_unit_reg;
    logic               s5_dir_reg;
    logic [14:0]        s5_og_reg;
    logic signed [17:0] s5_cell_reg;
    logic               s5_sat_reg;
    logic signed [15:0] s5_th_reg;

    // stage 6: hidden product
    logic [7:0]         s6_unit_reg;
    logic               s6_dir_reg;
    logic signed [17:0] s6_cell_reg;
    logic               s6_sat_reg;
    logic signed [31:0] s6_hp_reg;
    logic signed [31:0] s6_hp_next;

    // stage 7: output register
    logic [7:0]         s7_unit_reg;
    logic               s7_dir_reg;
    logic signed [15:0] s7_hidden_reg;
    logic signed [15:0] s7_hidden_next;
    logic signed [17:0] s7_cell_reg;
    logic               s7_sat_reg;

    // store write comes from the stage 3 -> 4 move
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic signed [17:0] rd_data;

    lcpu_pipe_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .hold    (hazard),
        .ctrl    (ctrl)
    );

    lcpu_cell_store u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (s4_cell_next),
        .rd_en   (ctrl.load[1]),
        .rd_addr (s1_addr_reg),
        .rd_data (rd_data)
    );

    // bank address: direction selects the upper half
    assign s1_addr_next = AW'(lcpu_pkg::unit_slot(s_unit_index))
                        + (s_direction ? AW'(lcpu_pkg::UNITS) : AW'(0));

    always_ff @(posedge aclk) begin
        if (ctrl.load[0]) begin
            s1_unit_reg  <= s_unit_index;
            s1_dir_reg   <= s_direction;
            s1_first_reg <= s_first_step;
            s1_addr_reg  <= s1_addr_next;
            s1_pi_reg    <= s_pre_input_gate;
            s1_pc_reg    <= s_pre_candidate;
            s1_po_reg    <= s_pre_output_gate;
            s1_pf_reg    <= s_pre_forget_gate;
        end
    end

    // activations; candidate tanh uses sigmoid on 2x (10 fraction bits)
    always_ff @(posedge aclk) begin
        if (ctrl.load[1]) begin
            s2_unit_reg  <= s1_unit_reg;
            s2_dir_reg   <= s1_dir_reg;
            s2_first_reg <= s1_first_reg;
            s2_addr_reg  <= s1_addr_reg;
            s2_ig_reg    <= lcpu_pkg::sigmoid_q14({{2{s1_pi_reg[15]}}, s1_pi_reg}, 1'b1);
            s2_cg_reg    <= lcpu_pkg::tanh_q14({{2{s1_pc_reg[15]}}, s1_pc_reg}, 1'b0);
            s2_og_reg    <= lcpu_pkg::sigmoid_q14({{2{s1_po_reg[15]}}, s1_po_reg}, 1'b1);
            s2_fg_reg    <= lcpu_pkg::sigmoid_q14({{2{s1_pf_reg[15]}}, s1_pf_reg}, 1'b1);
        end
    end

    // forward a cell written after (or on) the read edge
    always_ff @(posedge aclk) begin
        if (ctrl.load[1]) begin
            s2_use_mem_reg <= !(wr_en && (wr_addr == s1_addr_reg));
            s2_fwd_reg     <= s4_cell_next;
        end else if (wr_en && (wr_addr == s2_addr_reg)) begin
            s2_use_mem_reg <= 1'b0;
            s2_fwd_reg     <= s4_cell_next;
        end
    end

    assign s2_prev = s2_use_mem_reg ? rd_data : s2_fwd_reg;

    // hold a continuation while its predecessor's cell is still unresolved
    assign hazard = ctrl.valid[1] && !s2_first_reg && ctrl.valid[2]
                 && (s3_addr_reg == s2_addr_reg);

    // cell products
    assign s3_ci_next = s2_cg_reg * $signed({1'b0, s2_ig_reg});
    assign s3_fp_next = $signed({1'b0, s2_fg_reg}) * s2_prev;

    always_ff @(posedge aclk) begin
        if (ctrl.load[2]) begin
            s3_unit_reg  <= s2_unit_reg;
            s3_dir_reg   <= s2_dir_reg;
            s3_first_reg <= s2_first_reg;
            s3_addr_reg  <= s2_addr_reg;
            s3_og_reg    <= s2_og_reg;
            s3_ci_reg    <= s3_ci_next;
            s3_fp_reg    <= s3_fp_next;
        end
    end

    // cell sum and saturation
    always_comb begin
        cell_sum = lcpu_pkg::round_sh({{2{s3_ci_reg[31]}}, s3_ci_reg}, 16);
        if (!s3_first_reg) begin
            cell_sum = cell_sum + lcpu_pkg::round_sh(s3_fp_reg, 14);
        end
        s4_sat_next = 1'b1;
        if (cell_sum > lcpu_pkg::CELL_MAX) begin
            s4_cell_next = lcpu_pkg::CELL_MAX[17:0];
        end else if (cell_sum < lcpu_pkg::CELL_MIN) begin
            s4_cell_next = lcpu_pkg::CELL_MIN[17:0];
        end else begin
            s4_cell_next = cell_sum[17:0];
            s4_sat_next  = 1'b0;
        end
    end

    assign wr_en   = ctrl.advance[2];
    assign wr_addr = s3_addr_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.load[3]) begin
            s4_unit_reg <= s3_unit_reg;
            s4_dir_reg  <= s3_dir_reg;
            s4_og_reg   <= s3_og_reg;
            s4_cell_reg <= s4_cell_next;
            s4_sat_reg  <= s4_sat_next;
        end
    end

    // tanh of the Q5.12 cell: sigmoid on 2x has 11 fraction bits
    always_ff @(posedge aclk) begin
        if (ctrl.load[4]) begin
            s5_unit_reg <= s4_unit_reg;
            s5_dir_reg  <= s4_dir_reg;
            s5_og_reg   <= s4_og_reg;
            s5_cell_reg <= s4_cell_reg;
            s5_sat_reg  <= s4_sat_reg;
            s5_th_reg   <= lcpu_pkg::tanh_q14(s4_cell_reg, 1'b1);
        end
    end

    // hidden product
    assign s6_hp_next = s5_th_reg * $signed({1'b0, s5_og_reg});

    always_ff @(posedge aclk) begin
        if (ctrl.load[5]) begin
            s6_unit_reg <= s5_unit_reg;
            s6_dir_reg  <= s5_dir_reg;
            s6_cell_reg <= s5_cell_reg;
            s6_sat_reg  <= s5_sat_reg;
            s6_hp_reg   <= s6_hp_next;
        end
    end

    // output register: hidden back to Q1.14
    always_comb begin
        s7_hidden_next = 16'(lcpu_pkg::round_sh({{2{s6_hp_reg[31]}}, s6_hp_reg}, 14));
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load[6]) begin
            s7_unit_reg   <= s6_unit_reg;
            s7_dir_reg    <= s6_dir_reg;
            s7_cell_reg   <= s6_cell_reg;
            s7_sat_reg    <= s6_sat_reg;
            s7_hidden_reg <= s7_hidden_next;
        end
    end

    assign m_out_unit       = s7_unit_reg;
    assign m_out_direction  = s7_dir_reg;
    assign m_hidden_value   = s7_hidden_reg;
    assign m_cell_value     = s7_cell_reg;
    assign m_cell_saturated = s7_sat_reg;

endmodule

// ===== hdl/lcpu_checker.sv =====
// Port-level checks for the LSTM pointwise update, bound to the top level.
// Depends on lstm_cell_pointwise_update_macros.svh.
`include "lstm_cell_pointwise_update_macros.svh"

module lcpu_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic [7:0]         s_unit_index,
    input logic               s_direction,
    input logic               s_first_step,
    input logic signed [15:0] s_pre_input_gate,
    input logic signed [15:0] s_pre_candidate,
    input logic signed [15:0] s_pre_output_gate,
    input logic signed [15:0] s_pre_forget_gate,
    input logic               m_valid,
    input logic               m_ready,
    input logic [7:0]         m_out_unit,
    input logic               m_out_direction,
    input logic signed [15:0] m_hidden_value,
    input logic signed [17:0] m_cell_value,
    input logic               m_cell_saturated
);

    // result channel handshake
    `LCPU_ASSERT_HOLD(a_m_valid_hold, aclk, aresetn, m_valid, m_ready)
    `LCPU_ASSERT_STALL_STABLE(a_m_cell_stable, aclk, aresetn, m_valid, m_ready, m_cell_value)

    // pipeline empties on reset
    `LCPU_ASSERT_RESET(a_m_valid_reset, aclk, aresetn, m_valid)

    // hidden output stays within plus or minus one in Q1.14
    `LCPU_ASSERT_COND(a_hidden_range, aclk, aresetn, m_valid |-> ((m_hidden_value >= -16'sd16384) && (m_hidden_value <= 16'sd16384)))

    // a clipped cell sits on one of the rails
    `LCPU_ASSERT_COND(a_sat_rail, aclk, aresetn, (m_valid && m_cell_saturated) |-> ((m_cell_value == 18'sd131071) || (m_cell_value == -18'sd131072)))

endmodule

bind lstm_cell_pointwise_update lcpu_checker u_lcpu_checker (.*);
